[src/mrct_pkg.sv]
// Package for the matrix row and column totals block: sizes, widths,
// codes and shared types. Used by mrct_cell and matrix_row_column_totals.
package mrct_pkg;

	// Largest table supported
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 32;

	// Fixed port widths
	localparam int ELEM_W     = 16;
	localparam int VALUE_W    = 27;
	localparam int KIND_W     = 2;
	localparam int ROW_IDX_W  = 7;
	localparam int COL_IDX_W  = 6;
	localparam int NUM_ROWS_W = 7;
	localparam int NUM_COLS_W = 6;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	// Position and count widths
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
	localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

	// Sum widths, wide enough never to overflow
	localparam int COLSUM_W = ELEM_W + $clog2(MAX_ROWS) + 1;
	localparam int ROWACC_W = ELEM_W + $clog2(MAX_COLS) + 1;
	localparam int GRAND_W  = ELEM_W + $clog2(MAX_ROWS) + $clog2(MAX_COLS) + 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_ROWS = 1'b0,
		CFG_NUM_COLS = 1'b1
	} cfg_idx_t;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ELEM  = 2'd0,
		KIND_ROW   = 2'd1,
		KIND_COL   = 2'd2,
		KIND_TOTAL = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_ACC,
		ST_ROW,
		ST_DUMP
	} state_t;

	// Control shared by every column cell
	typedef struct packed {
		logic add;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

[src/mrct_cell.sv]
// One column cell: holds the running sum of one column and hands it to
// its neighbour when the sums row is shifted out. Depends on mrct_pkg.
module mrct_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mrct_pkg::cell_ctrl_t                   ctrl,
	input  logic                                   sel,
	input  logic signed [mrct_pkg::ELEM_W-1:0]     element,
	input  logic signed [mrct_pkg::COLSUM_W-1:0]   sum_in,
	output logic signed [mrct_pkg::COLSUM_W-1:0]   sum
);

	logic signed [mrct_pkg::COLSUM_W-1:0] sum_q;

	// Clear after a table, take the neighbour's sum while shifting, else add when selected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.shift) begin
			sum_q <= sum_in;
		end else if (ctrl.add && sel) begin
			sum_q <= sum_q + mrct_pkg::COLSUM_W'(element);
		end
	end

	assign sum = sum_q;

endmodule

[src/matrix_row_column_totals.sv]
// Matrix row and column totals: top level with sequencer, output register
// and the chain of column cells. Depends on mrct_pkg and mrct_cell.
//
// Elements enter one per item in row-major order and each is returned as
// an element entry. An element that closes a row also brings out its row
// sum as a row entry; no element is taken while the row sum is issued.
// After the last element of the table the column sums leave the cell chain
// one per cycle while the output is not stalled, shifted towards cell 0,
// followed by the grand total; no element is taken meanwhile. The single
// output register carries one result per cycle when not stalled. Reset
// clears all sums at once; the block is ready straight after reset.
// Configure num_rows and num_cols only while the block is idle.
module matrix_row_column_totals (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration
	input  logic                                    cfg_we,
	input  logic [mrct_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mrct_pkg::CFG_W-1:0]              cfg_data,
	// input items
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [mrct_pkg::ELEM_W-1:0]      element,
	// result items
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [mrct_pkg::VALUE_W-1:0]     value,
	output logic [mrct_pkg::KIND_W-1:0]             kind,
	output logic [mrct_pkg::ROW_IDX_W-1:0]          row_index,
	output logic [mrct_pkg::COL_IDX_W-1:0]          col_index,
	output logic                                    last,
	output logic                                    end_of_table
);

	localparam int RC_W = mrct_pkg::ROW_CNT_W;
	localparam int CC_W = mrct_pkg::COL_CNT_W;

	// Configuration registers
	logic [mrct_pkg::NUM_ROWS_W-1:0] num_rows_q;
	logic [mrct_pkg::NUM_COLS_W-1:0] num_cols_q;

	// Sequencer and accumulation state
	mrct_pkg::state_t                      state_q, state_nxt;
	logic [mrct_pkg::ROW_W-1:0]            cur_row_q;
	logic [mrct_pkg::COL_W-1:0]            cur_col_q;
	logic signed [mrct_pkg::ROWACC_W-1:0]  row_acc_q;
	logic signed [mrct_pkg::GRAND_W-1:0]   grand_q;
	logic                                  table_end_q;
	logic [CC_W-1:0]                       dump_cnt_q;

	// Output register
	logic                                  out_valid_q;
	logic signed [mrct_pkg::VALUE_W-1:0]   value_q;
	mrct_pkg::kind_t                       kind_q;
	logic [mrct_pkg::ROW_IDX_W-1:0]        row_q;
	logic [mrct_pkg::COL_IDX_W-1:0]        col_q;
	logic                                  last_q;
	logic                                  eot_q;

	// Combinational signals
	logic [RC_W-1:0]                       rows_eff;
	logic [CC_W-1:0]                       cols_eff;
	logic [CC_W-1:0]                       col_next;
	logic [RC_W-1:0]                       row_next;
	logic                                  row_end;
	logic                                  table_end;
	logic                                  adv;
	logic                                  in_acc;
	logic                                  dump_done;
	logic                                  emit;
	logic signed [mrct_pkg::VALUE_W-1:0]   o_value;
	mrct_pkg::kind_t                       o_kind;
	logic [mrct_pkg::ROW_IDX_W-1:0]        o_row;
	logic [mrct_pkg::COL_IDX_W-1:0]        o_col;
	logic                                  o_last;
	logic                                  o_eot;
	mrct_pkg::cell_ctrl_t                  cell_ctrl;
	logic signed [mrct_pkg::COLSUM_W-1:0]  cell_sum [mrct_pkg::MAX_COLS];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= mrct_pkg::NUM_ROWS_W'(1);
			num_cols_q <= mrct_pkg::NUM_COLS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mrct_pkg::CFG_NUM_ROWS: num_rows_q <= mrct_pkg::NUM_ROWS_W'(cfg_data);
				mrct_pkg::CFG_NUM_COLS: num_cols_q <= mrct_pkg::NUM_COLS_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Clamp the counts to the supported range
	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = RC_W'(1);
		end else if (32'(num_rows_q) > mrct_pkg::MAX_ROWS) begin
			rows_eff = RC_W'(mrct_pkg::MAX_ROWS);
		end else begin
			rows_eff = RC_W'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = CC_W'(1);
		end else if (32'(num_cols_q) > mrct_pkg::MAX_COLS) begin
			cols_eff = CC_W'(mrct_pkg::MAX_COLS);
		end else begin
			cols_eff = CC_W'(num_cols_q);
		end
	end

	// Position tests and handshake
	assign col_next  = CC_W'(cur_col_q) + CC_W'(1);
	assign row_next  = RC_W'(cur_row_q) + RC_W'(1);
	assign row_end   = (col_next >= cols_eff);
	assign table_end = row_end && (row_next >= rows_eff);
	assign dump_done = (dump_cnt_q == cols_eff);
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == mrct_pkg::ST_ACC) && adv);
	assign in_acc    = in_valid && !in_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mrct_pkg::ST_ACC: begin
				if (in_acc && row_end) state_nxt = mrct_pkg::ST_ROW;
			end
			mrct_pkg::ST_ROW: begin
				if (adv) state_nxt = table_end_q ? mrct_pkg::ST_DUMP : mrct_pkg::ST_ACC;
			end
			mrct_pkg::ST_DUMP: begin
				if (adv && dump_done) state_nxt = mrct_pkg::ST_ACC;
			end
			default: state_nxt = mrct_pkg::ST_ACC;
		endcase
	end

	// Result selection and cell control
	always_comb begin
		emit      = 1'b0;
		o_value   = '0;
		o_kind    = mrct_pkg::KIND_ELEM;
		o_row     = mrct_pkg::ROW_IDX_W'(cur_row_q);
		o_col     = mrct_pkg::COL_IDX_W'(cur_col_q);
		o_last    = 1'b0;
		o_eot     = 1'b0;
		cell_ctrl = '0;
		case (state_q)
			mrct_pkg::ST_ACC: begin
				emit          = in_acc;
				o_value       = mrct_pkg::VALUE_W'(element);
				o_last        = !row_end;
				cell_ctrl.add = in_acc;
			end
			mrct_pkg::ST_ROW: begin
				emit    = 1'b1;
				o_value = mrct_pkg::VALUE_W'(row_acc_q);
				o_kind  = mrct_pkg::KIND_ROW;
				o_col   = mrct_pkg::COL_IDX_W'(cols_eff);
				o_last  = !table_end_q;
			end
			mrct_pkg::ST_DUMP: begin
				emit  = 1'b1;
				o_row = mrct_pkg::ROW_IDX_W'(rows_eff);
				if (!dump_done) begin
					o_value         = mrct_pkg::VALUE_W'(cell_sum[0]);
					o_kind          = mrct_pkg::KIND_COL;
					o_col           = mrct_pkg::COL_IDX_W'(dump_cnt_q);
					cell_ctrl.shift = adv;
				end else begin
					o_value         = mrct_pkg::VALUE_W'(grand_q);
					o_kind          = mrct_pkg::KIND_TOTAL;
					o_col           = mrct_pkg::COL_IDX_W'(cols_eff);
					o_last          = 1'b1;
					o_eot           = 1'b1;
					cell_ctrl.clear = adv;
				end
			end
			default: ;
		endcase
	end

	// Sequencer, position and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrct_pkg::ST_ACC;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			row_acc_q   <= '0;
			grand_q     <= '0;
			table_end_q <= 1'b0;
			dump_cnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				mrct_pkg::ST_ACC: begin
					if (in_acc) begin
						row_acc_q   <= row_acc_q + mrct_pkg::ROWACC_W'(element);
						grand_q     <= grand_q + mrct_pkg::GRAND_W'(element);
						cur_col_q   <= row_end ? '0 : mrct_pkg::COL_W'(col_next);
						table_end_q <= table_end;
					end
				end
				mrct_pkg::ST_ROW: begin
					if (adv) begin
						row_acc_q  <= '0;
						dump_cnt_q <= '0;
						if (!table_end_q) cur_row_q <= mrct_pkg::ROW_W'(row_next);
					end
				end
				mrct_pkg::ST_DUMP: begin
					if (adv) begin
						if (!dump_done) begin
							dump_cnt_q <= dump_cnt_q + CC_W'(1);
						end else begin
							grand_q   <= '0;
							cur_row_q <= '0;
							cur_col_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: load when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			value_q <= o_value;
			kind_q  <= o_kind;
			row_q   <= o_row;
			col_q   <= o_col;
			last_q  <= o_last;
			eot_q   <= o_eot;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign kind         = kind_q;
	assign row_index    = row_q;
	assign col_index    = col_q;
	assign last         = last_q;
	assign end_of_table = eot_q;

	// Chain of column cells, shifting towards cell 0
	for (genvar i = 0; i < mrct_pkg::MAX_COLS; i++) begin : g_cell
		logic signed [mrct_pkg::COLSUM_W-1:0] nbr_sum;
		if (i == mrct_pkg::MAX_COLS - 1) begin : g_tail
			assign nbr_sum = '0;
		end else begin : g_link
			assign nbr_sum = cell_sum[i+1];
		end
		mrct_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.sel     (cur_col_q == mrct_pkg::COL_W'(i)),
			.element (element),
			.sum_in  (nbr_sum),
			.sum     (cell_sum[i])
		);
	end

`ifndef ASSERT_OFF
	a_eot_is_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eot_q) |-> (last_q && kind_q == mrct_pkg::KIND_TOTAL))
		else $error("end of table without a closing grand total");

	a_dump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrct_pkg::ST_DUMP) |-> (dump_cnt_q <= cols_eff))
		else $error("column sum counter ran past the column count");

	a_row_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrct_pkg::ST_ROW) |-> (cur_col_q == '0))
		else $error("column position not rewound at row end");

	a_clear_after_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrct_pkg::ST_DUMP && adv && dump_done)
		|=> (grand_q == '0 && cur_row_q == '0 && cell_sum[0] == '0))
		else $error("sums not cleared after the table");
`endif

endmodule
